// ===== hdl/ptca_pkg.sv =====
// Shared constants and types of the per-task channel accumulator.
`default_nettype none
package ptca_pkg;
  localparam int TASK_ENTRIES = 16;
  localparam int SAMPLE_BITS  = 12;
  localparam int COUNT_BITS   = 32;
  localparam int NUM_CH       = 4;
  localparam int AVG_BITS     = 12;
  localparam int SMP_W        = 12;
  localparam int TID_W        = 4;
  localparam int CNT_OUT_W    = 32;
  localparam logic [AVG_BITS-1:0] AVG_MAX = 12'hFFF;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIVIDE} state_t;

  typedef struct packed {
    logic add;
    logic alloc;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic             func;
    logic [TID_W-1:0] task_id;
    logic [SMP_W-1:0] sample_ch0;
    logic [SMP_W-1:0] sample_ch1;
    logic [SMP_W-1:0] sample_ch2;
    logic [SMP_W-1:0] sample_ch3;
  } in_item_t;

  typedef struct packed {
    logic                entry_valid;
    logic [TID_W-1:0]    report_task;
    logic [CNT_OUT_W-1:0] frame_count;
    logic [AVG_BITS-1:0] avg_ch0;
    logic [AVG_BITS-1:0] avg_ch1;
    logic [AVG_BITS-1:0] avg_ch2;
    logic [AVG_BITS-1:0] avg_ch3;
    logic                last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/per_task_channel_accumulator_top.sv =====
// Top level of the per-task channel accumulator: cell chain, divider and flush sequencer.
`default_nettype none
// A sample frame (func 0) is taken with busy left low, so frames may arrive
// every cycle while no flush is running. A flush (func 1) reports each used
// entry in order of first appearance; each entry passes a load step, 13 steps
// of the bit-serial divider that forms all four averages, and a result step. An
// empty-table flush gives its single result on the next cycle. Results appear on
// res for one cycle with res_valid high and cannot be held off; busy is high
// until the last result has been issued. The table is empty after every flush.
module per_task_channel_accumulator_top #(
  parameter int TASK_ENTRIES = ptca_pkg::TASK_ENTRIES,
  parameter int SAMPLE_BITS  = ptca_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS   = ptca_pkg::COUNT_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire ptca_pkg::in_item_t  item,
  output logic                     busy,
  output logic                     res_valid,
  output ptca_pkg::out_item_t      res
);
  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int UW    = $clog2(TASK_ENTRIES + 1);
  localparam int NC    = ptca_pkg::NUM_CH;
  localparam logic [ptca_pkg::SMP_W-1:0] SMASK =
    ptca_pkg::SMP_W'((1 << SAMPLE_BITS) - 1);

  ptca_pkg::state_t   state, state_next;
  logic [UW-1:0]      used;
  logic               fire, acc_fire, flush_fire, hit, pop, div_start, div_done;
  logic [NC-1:0][SUM_W-1:0] smp;
  logic [NC-1:0][ptca_pkg::AVG_BITS-1:0] avg;

  ptca_pkg::cell_ctl_t ctl [TASK_ENTRIES];
  logic                     c_valid [TASK_ENTRIES+1];
  logic [ptca_pkg::TID_W-1:0] c_tid [TASK_ENTRIES+1];
  logic [COUNT_BITS-1:0]    c_count [TASK_ENTRIES+1];
  logic [NC-1:0][SUM_W-1:0] c_sums [TASK_ENTRIES+1];
  logic [TASK_ENTRIES-1:0]  match;

  assign busy       = (state != ptca_pkg::ST_IDLE);
  assign fire       = start && !busy;
  assign acc_fire   = fire && !item.func;
  assign flush_fire = fire && item.func;
  assign hit        = |match;

  // masked samples, widened to sum width
  assign smp[0] = SUM_W'(item.sample_ch0 & SMASK);
  assign smp[1] = SUM_W'(item.sample_ch1 & SMASK);
  assign smp[2] = SUM_W'(item.sample_ch2 & SMASK);
  assign smp[3] = SUM_W'(item.sample_ch3 & SMASK);

  // empty tail feeding the last cell
  assign c_valid[TASK_ENTRIES] = 1'b0;
  assign c_tid[TASK_ENTRIES]   = '0;
  assign c_count[TASK_ENTRIES] = '0;
  assign c_sums[TASK_ENTRIES]  = '0;

  // cell chain, head at index 0
  for (genvar i = 0; i < TASK_ENTRIES; i++) begin : g_cell
    assign ctl[i].add   = acc_fire && match[i];
    assign ctl[i].alloc = acc_fire && !hit && (used == UW'(i));
    assign ctl[i].shift = pop;
    ptca_cell #(.SUM_W(SUM_W), .COUNT_BITS(COUNT_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[i]),
      .id      (item.task_id),
      .smp     (smp),
      .nb_valid(c_valid[i+1]),
      .nb_tid  (c_tid[i+1]),
      .nb_count(c_count[i+1]),
      .nb_sums (c_sums[i+1]),
      .valid   (c_valid[i]),
      .tid     (c_tid[i]),
      .count   (c_count[i]),
      .sums    (c_sums[i]),
      .match   (match[i])
    );
  end

  ptca_div #(.SUM_W(SUM_W), .COUNT_BITS(COUNT_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .sums (c_sums[0]),
    .count(c_count[0]),
    .done (div_done),
    .avg  (avg)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // flush sequencing
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    pop        = 1'b0;
    case (state)
      ptca_pkg::ST_IDLE: begin
        if (flush_fire && used != '0) begin
          state_next = ptca_pkg::ST_LOAD;
        end
      end
      ptca_pkg::ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ptca_pkg::ST_DIVIDE;
      end
      ptca_pkg::ST_DIVIDE: begin
        if (div_done) begin
          pop        = 1'b1;
          state_next = (used == UW'(1)) ? ptca_pkg::ST_IDLE : ptca_pkg::ST_LOAD;
        end
      end
      default: state_next = ptca_pkg::ST_IDLE;
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (pop) begin
      used <= used - UW'(1);
    end else if (acc_fire && !hit && used != UW'(TASK_ENTRIES)) begin
      used <= used + UW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= pop || (flush_fire && used == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.entry_valid <= 1'b1;
      res.report_task <= c_tid[0];
      res.frame_count <= ptca_pkg::CNT_OUT_W'(c_count[0]);
      res.avg_ch0     <= avg[0];
      res.avg_ch1     <= avg[1];
      res.avg_ch2     <= avg[2];
      res.avg_ch3     <= avg[3];
      res.last        <= (used == UW'(1));
    end else if (flush_fire) begin
      res <= '{entry_valid: 1'b0, report_task: '0, frame_count: '0, avg_ch0: '0,
               avg_ch1: '0, avg_ch2: '0, avg_ch3: '0, last: 1'b1};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ptca_cell.sv =====
// One table entry: task tag, frame count and channel sums, shifting towards the head on flush.
`default_nettype none
module ptca_cell #(
  parameter int SUM_W      = 44,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ptca_pkg::cell_ctl_t           ctl,
  input  wire logic [ptca_pkg::TID_W-1:0]    id,
  input  wire logic [ptca_pkg::NUM_CH-1:0][SUM_W-1:0] smp,
  input  wire logic                          nb_valid,
  input  wire logic [ptca_pkg::TID_W-1:0]    nb_tid,
  input  wire logic [COUNT_BITS-1:0]         nb_count,
  input  wire logic [ptca_pkg::NUM_CH-1:0][SUM_W-1:0] nb_sums,
  output logic                               valid,
  output logic [ptca_pkg::TID_W-1:0]         tid,
  output logic [COUNT_BITS-1:0]              count,
  output logic [ptca_pkg::NUM_CH-1:0][SUM_W-1:0] sums,
  output logic                               match
);
  logic sat;

  assign sat   = &count;
  assign match = valid && (tid == id);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= nb_valid;
    end else if (ctl.alloc) begin
      valid <= 1'b1;
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tid   <= nb_tid;
      count <= nb_count;
      sums  <= nb_sums;
    end else if (ctl.alloc) begin
      tid   <= id;
      count <= COUNT_BITS'(1);
      sums  <= smp;
    end else if (ctl.add && !sat) begin
      count <= count + COUNT_BITS'(1);
      for (int c = 0; c < ptca_pkg::NUM_CH; c++) begin
        sums[c] <= sums[c] + smp[c];
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ptca_div.sv =====
// Four-lane restoring divider giving clamped 12-bit averages, one quotient bit per cycle.
`default_nettype none
module ptca_div #(
  parameter int SUM_W      = 44,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ptca_pkg::NUM_CH-1:0][SUM_W-1:0] sums,
  input  wire logic [COUNT_BITS-1:0]         count,
  output logic                               done,
  output logic [ptca_pkg::NUM_CH-1:0][ptca_pkg::AVG_BITS-1:0] avg
);
  localparam int W    = SUM_W + ptca_pkg::AVG_BITS;
  localparam int QW   = ptca_pkg::AVG_BITS + 1;
  localparam int STEP_W = $clog2(QW);

  logic                     run;
  logic [STEP_W-1:0]        step;
  logic [W-1:0]             dvs;
  logic                     zero_cnt;
  logic [ptca_pkg::NUM_CH-1:0][W-1:0]  rem;
  logic [ptca_pkg::NUM_CH-1:0][QW-1:0] q;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(QW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per lane per cycle, divisor walks right
  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= W'(count) << ptca_pkg::AVG_BITS;
      zero_cnt <= (count == '0);
      for (int c = 0; c < ptca_pkg::NUM_CH; c++) begin
        rem[c] <= W'(sums[c]);
        q[c]   <= '0;
      end
    end else if (run) begin
      dvs <= dvs >> 1;
      for (int c = 0; c < ptca_pkg::NUM_CH; c++) begin
        if (rem[c] >= dvs) begin
          rem[c] <= rem[c] - dvs;
          q[c]   <= {q[c][QW-2:0], 1'b1};
        end else begin
          q[c]   <= {q[c][QW-2:0], 1'b0};
        end
      end
    end
  end

  // top quotient bit means the average is at least 4096
  always_comb begin
    for (int c = 0; c < ptca_pkg::NUM_CH; c++) begin
      if (zero_cnt) begin
        avg[c] = '0;
      end else if (q[c][QW-1]) begin
        avg[c] = ptca_pkg::AVG_MAX;
      end else begin
        avg[c] = q[c][QW-2:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench of the per-task channel accumulator.
`timescale 1ns / 1ps
module tb;
  localparam logic FN_ACC   = 1'b0;
  localparam logic FN_FLUSH = 1'b1;
  localparam int   N_RANDOM = 500;

  logic                clk;
  logic                rst;
  logic                start;
  ptca_pkg::in_item_t  item;
  logic                busy;
  logic                res_valid;
  ptca_pkg::out_item_t res;

  per_task_channel_accumulator_top i_dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .res_valid(res_valid), .res(res)
  );

  // predictor state: table in order of first appearance
  logic [ptca_pkg::TID_W-1:0] tbl_task [ptca_pkg::TASK_ENTRIES];
  logic [43:0] tbl_sum [ptca_pkg::TASK_ENTRIES][ptca_pkg::NUM_CH];
  logic [31:0] tbl_cnt [ptca_pkg::TASK_ENTRIES];
  int          tbl_used;

  ptca_pkg::out_item_t report_q[$];
  int        n_errors;
  int        n_reports;
  int        n_frames;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous limit: ~600 items, each flush reporting up to 16 entries
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void table_clear();
    tbl_used = 0;
    for (int e = 0; e < ptca_pkg::TASK_ENTRIES; e++) begin
      tbl_cnt[e] = '0;
      for (int c = 0; c < ptca_pkg::NUM_CH; c++) tbl_sum[e][c] = '0;
    end
  endfunction

  // work out the reports that one accepted item causes
  function automatic void predict_item(ptca_pkg::in_item_t it);
    int slot;
    logic [ptca_pkg::SMP_W-1:0] smp [ptca_pkg::NUM_CH];
    ptca_pkg::out_item_t r;
    logic [43:0] q;
    smp[0] = it.sample_ch0; smp[1] = it.sample_ch1;
    smp[2] = it.sample_ch2; smp[3] = it.sample_ch3;
    if (it.func == FN_ACC) begin
      slot = tbl_used;
      for (int e = 0; e < tbl_used; e++)
        if (slot == tbl_used && tbl_task[e] == it.task_id) slot = e;
      if (slot == tbl_used) begin
        if (tbl_used >= ptca_pkg::TASK_ENTRIES) return;
        tbl_task[slot] = it.task_id;
        tbl_used++;
      end
      if (tbl_cnt[slot] == 32'hFFFF_FFFF) return;
      for (int c = 0; c < ptca_pkg::NUM_CH; c++) tbl_sum[slot][c] += 44'(smp[c]);
      tbl_cnt[slot]++;
    end else begin
      if (tbl_used == 0) begin
        r = '0;
        r.last = 1'b1;
        report_q.push_back(r);
      end
      for (int e = 0; e < tbl_used; e++) begin
        r = '0;
        r.entry_valid = 1'b1;
        r.report_task = tbl_task[e];
        r.frame_count = tbl_cnt[e];
        for (int c = 0; c < ptca_pkg::NUM_CH; c++) begin
          q = (tbl_cnt[e] == 0) ? 44'd0 : tbl_sum[e][c] / 44'(tbl_cnt[e]);
          if (q > 44'(ptca_pkg::AVG_MAX)) q = 44'(ptca_pkg::AVG_MAX);
          case (c)
            0: r.avg_ch0 = q[ptca_pkg::AVG_BITS-1:0];
            1: r.avg_ch1 = q[ptca_pkg::AVG_BITS-1:0];
            2: r.avg_ch2 = q[ptca_pkg::AVG_BITS-1:0];
            default: r.avg_ch3 = q[ptca_pkg::AVG_BITS-1:0];
          endcase
        end
        r.last = (e + 1 == tbl_used);
        report_q.push_back(r);
      end
      table_clear();
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    ptca_pkg::out_item_t exp_r;
    if (!rst && res_valid) begin
      n_reports++;
      if (report_q.size() == 0) begin
        $error("unexpected report, none pending");
        n_errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (res.entry_valid !== exp_r.entry_valid) begin
          $error("entry_valid exp %0h got %0h", exp_r.entry_valid, res.entry_valid);
          n_errors++;
        end
        if (res.report_task !== exp_r.report_task) begin
          $error("report_task exp %0h got %0h", exp_r.report_task, res.report_task);
          n_errors++;
        end
        if (res.frame_count !== exp_r.frame_count) begin
          $error("frame_count exp %0d got %0d", exp_r.frame_count, res.frame_count);
          n_errors++;
        end
        if (res.avg_ch0 !== exp_r.avg_ch0) begin
          $error("avg_ch0 exp %0d got %0d", exp_r.avg_ch0, res.avg_ch0);
          n_errors++;
        end
        if (res.avg_ch1 !== exp_r.avg_ch1) begin
          $error("avg_ch1 exp %0d got %0d", exp_r.avg_ch1, res.avg_ch1);
          n_errors++;
        end
        if (res.avg_ch2 !== exp_r.avg_ch2) begin
          $error("avg_ch2 exp %0d got %0d", exp_r.avg_ch2, res.avg_ch2);
          n_errors++;
        end
        if (res.avg_ch3 !== exp_r.avg_ch3) begin
          $error("avg_ch3 exp %0d got %0d", exp_r.avg_ch3, res.avg_ch3);
          n_errors++;
        end
        if (res.last !== exp_r.last) begin
          $error("last exp %0h got %0h", exp_r.last, res.last);
          n_errors++;
        end
      end
    end
  end

  // hand one item over; start stays high between back-to-back items
  task automatic send_item(ptca_pkg::in_item_t it, bit calm);
    if (!calm && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(it);
    n_frames++;
  endtask

  function automatic ptca_pkg::in_item_t frame(logic [ptca_pkg::TID_W-1:0] id,
                                               logic [ptca_pkg::SMP_W-1:0] a,
                                               logic [ptca_pkg::SMP_W-1:0] b,
                                               logic [ptca_pkg::SMP_W-1:0] c,
                                               logic [ptca_pkg::SMP_W-1:0] d);
    ptca_pkg::in_item_t it;
    it.func = FN_ACC; it.task_id = id;
    it.sample_ch0 = a; it.sample_ch1 = b; it.sample_ch2 = c; it.sample_ch3 = d;
    return it;
  endfunction

  function automatic logic [ptca_pkg::SMP_W-1:0] rand_smp();
    return ptca_pkg::SMP_W'($urandom);
  endfunction

  function automatic logic [ptca_pkg::TID_W-1:0] rand_tid();
    return ptca_pkg::TID_W'($urandom);
  endfunction

  function automatic ptca_pkg::in_item_t rand_item(logic fn,
                                                   logic [ptca_pkg::TID_W-1:0] id);
    ptca_pkg::in_item_t it;
    it = frame(id, rand_smp(), rand_smp(), rand_smp(), rand_smp());
    it.func = fn;
    return it;
  endfunction

  // directed stimulus table
  ptca_pkg::in_item_t  dir_tbl [$];
  ptca_pkg::out_item_t exp_tbl [$];
  bit                  has_exp [$];

  initial begin
    ptca_pkg::in_item_t  it;
    ptca_pkg::out_item_t er;
    int        n_id;
    logic [ptca_pkg::TID_W-1:0] ids [4];
    n_errors = 0; n_reports = 0; n_frames = 0;
    table_clear();
    rst = 1'b1; start = 1'b0; item = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty flush straight after reset, with noise on the ignored fields
    it = rand_item(FN_FLUSH, 4'hF);
    er = '0; er.last = 1'b1;
    dir_tbl.push_back(it); exp_tbl.push_back(er); has_exp.push_back(1'b1);
    // one frame at full scale, one at zero: averages 2047
    dir_tbl.push_back(frame(4'h0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    exp_tbl.push_back('0); has_exp.push_back(1'b0);
    dir_tbl.push_back(frame(4'h0, 12'h000, 12'h000, 12'h000, 12'h000));
    exp_tbl.push_back('0); has_exp.push_back(1'b0);
    it = rand_item(FN_FLUSH, 4'h0);
    er = '0; er.entry_valid = 1'b1; er.report_task = 4'h0; er.frame_count = 32'd2;
    er.avg_ch0 = 12'd2047; er.avg_ch1 = 12'd2047; er.avg_ch2 = 12'd2047;
    er.avg_ch3 = 12'd2047; er.last = 1'b1;
    dir_tbl.push_back(it); exp_tbl.push_back(er); has_exp.push_back(1'b1);
    // fill all sixteen entries in reverse order, then one more frame on a held entry
    for (int k = 15; k >= 0; k--) begin
      dir_tbl.push_back(frame(k[3:0], rand_smp(), rand_smp(), rand_smp(), rand_smp()));
      exp_tbl.push_back('0); has_exp.push_back(1'b0);
    end
    dir_tbl.push_back(frame(4'h3, 12'hAAA, 12'h555, 12'hFFF, 12'h001));
    exp_tbl.push_back('0); has_exp.push_back(1'b0);
    dir_tbl.push_back(rand_item(FN_FLUSH, 4'h7));
    exp_tbl.push_back('0); has_exp.push_back(1'b0);

    foreach (dir_tbl[i]) begin
      if (has_exp[i]) begin
        if (report_q.size() != 0) begin
          start <= 1'b0;
          wait (report_q.size() == 0);
          @(posedge clk);
        end
        send_item(dir_tbl[i], 1'b1);
        if (report_q.size() != 0) begin
          er = report_q[0];
          if (er !== exp_tbl[i]) begin
            $error("directed row %0d: predictor disagrees with typed result", i);
            n_errors++;
          end
        end
      end else begin
        send_item(dir_tbl[i], 1'b1);
      end
    end

    // random part: bursts on up to four tasks or on random task ids, then a flush
    while (n_frames < N_RANDOM + dir_tbl.size()) begin
      n_id = $urandom_range(1, 17);
      for (int k = 0; k < 4; k++) ids[k] = rand_tid();
      repeat ($urandom_range(0, 20)) begin
        if (n_id > 16) it = rand_item(FN_ACC, rand_tid());
        else it = rand_item(FN_ACC, ids[$urandom_range(0, (n_id % 4))]);
        // stretch without idling in the middle of the run
        send_item(it, n_frames > 200 && n_frames < 280);
      end
      send_item(rand_item(FN_FLUSH, rand_tid()), 1'b0);
      // sender sometimes holds off until the whole report has drained
      if ($urandom_range(3) == 0) begin
        start <= 1'b0;
        wait (report_q.size() == 0);
        @(posedge clk);
      end
    end
    start <= 1'b0;

    wait (report_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d items (frames and flushes), checked %0d report results.",
             n_frames, n_reports);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ptca_pkg.sv
hdl/ptca_cell.sv
hdl/ptca_div.sv
hdl/per_task_channel_accumulator_top.sv
test/tb.sv
